// ===== rtl/srmlp_pkg.sv =====
// Package for the server rules mod list parser.
// Holds the transaction payload types, the parse phase encoding and the field constants.
// No dependencies.
package srmlp_pkg;

    // The header is seven bytes, indexed 0 to 6.
    localparam logic [2:0] HDR_LAST_IDX  = 3'd6;
    // Hash and workshop id fields are four bytes, indexed 0 to 3.
    localparam logic [2:0] WORD_LAST_IDX = 3'd3;
    localparam logic [7:0] ID_LEN        = 8'h04;
    localparam logic [7:0] PRINT_LO      = 8'h20;
    localparam logic [7:0] PRINT_HI      = 8'h7E;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_CHAR   = 2'd1,
        KIND_MOD    = 2'd2,
        KIND_BADLEN = 2'd3
    } kind_t;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_HEADER  = 7'b0000010,
        PH_HASH    = 7'b0000100,
        PH_IDLEN   = 7'b0001000,
        PH_ID      = 7'b0010000,
        PH_NAMELEN = 7'b0100000,
        PH_NAME    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_start;
    } byte_item_t;

    typedef struct packed {
        kind_t       record_kind;
        logic [7:0]  hdr_version;
        logic [7:0]  hdr_overflow;
        logic [15:0] dlc_mask;
        logic        dlc_single;
        logic [7:0]  mod_count;
        logic [31:0] rec_hash;
        logic [31:0] workshop_id;
        logic [7:0]  name_length;
        logic [6:0]  name_char;
        logic [7:0]  bad_id_length;
        logic        end_of_message;
    } rec_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  idx;
        logic [7:0]  version;
        logic [7:0]  overflow;
        logic [15:0] dlc;
        logic [31:0] hash;
        logic [31:0] id;
        logic [7:0]  name_len;
        logic [7:0]  name_rem;
        logic [7:0]  mods_rem;
    } parse_state_t;

    // Parse state after reset: idle, everything else cleared.
    localparam parse_state_t STATE_RESET = '{
        phase:    PH_IDLE,
        idx:      3'd0,
        version:  8'd0,
        overflow: 8'd0,
        dlc:      16'd0,
        hash:     32'd0,
        id:       32'd0,
        name_len: 8'd0,
        name_rem: 8'd0,
        mods_rem: 8'd0
    };

endpackage

// ===== rtl/srmlp_step.sv =====
// Next-state and result logic for one received byte of the mod list parser.
// Purely combinational; depends on srmlp_pkg.
module srmlp_step (
    input  srmlp_pkg::parse_state_t cur,
    input  srmlp_pkg::byte_item_t   item,
    output srmlp_pkg::parse_state_t nxt,
    output logic                    res_valid,
    output srmlp_pkg::rec_item_t    res
);
    import srmlp_pkg::*;

    phase_t      ph;
    logic [2:0]  idx;
    logic [7:0]  b;
    logic        finish;
    logic [6:0]  fin_char;
    logic [7:0]  mods_dec;
    logic [7:0]  rem_dec;
    logic [15:0] dlc_word;

    always_comb
    begin
        b        = item.data_byte;
        ph       = cur.phase;
        idx      = cur.idx;
        finish   = 1'b0;
        fin_char = '0;
        mods_dec = cur.mods_rem - 8'd1;
        rem_dec  = cur.name_rem - 8'd1;
        dlc_word = {b, cur.dlc[7:0]};
        res       = '0;
        res_valid = 1'b0;

        // A start flag abandons any message in progress.
        if (item.message_start)
        begin
            ph  = PH_HEADER;
            idx = '0;
        end

        nxt       = cur;
        nxt.phase = ph;
        nxt.idx   = idx;

        case (ph)
            PH_HEADER:
            begin
                nxt.idx = idx + 3'd1;
                case (idx)
                    3'd0: nxt.version  = b;
                    3'd1: nxt.overflow = b;
                    3'd2: nxt.dlc      = {8'h00, b};
                    3'd3: nxt.dlc      = dlc_word;
                    HDR_LAST_IDX:
                    begin
                        res_valid          = 1'b1;
                        res.record_kind    = KIND_HEADER;
                        res.hdr_version    = cur.version;
                        res.hdr_overflow   = cur.overflow;
                        res.dlc_mask       = cur.dlc;
                        res.dlc_single     = (cur.dlc != 16'd0) &&
                                             ((cur.dlc & (cur.dlc - 16'd1)) == 16'd0);
                        res.mod_count      = b;
                        nxt.mods_rem       = b;
                        nxt.idx            = '0;
                        if (b == 8'd0)
                        begin
                            res.end_of_message = 1'b1;
                            nxt.phase          = PH_IDLE;
                        end
                        else
                        begin
                            nxt.phase = PH_HASH;
                        end
                    end
                    default: ;
                endcase
            end
            PH_HASH:
            begin
                // Little-endian: bytes shift in from the top.
                nxt.hash = {b, cur.hash[31:8]};
                nxt.idx  = idx + 3'd1;
                if (idx == WORD_LAST_IDX)
                    nxt.phase = PH_IDLEN;
            end
            PH_IDLEN:
            begin
                if (b != ID_LEN)
                begin
                    res_valid          = 1'b1;
                    res.record_kind    = KIND_BADLEN;
                    res.bad_id_length  = b;
                    res.end_of_message = 1'b1;
                    nxt.phase          = PH_IDLE;
                end
                else
                begin
                    nxt.phase = PH_ID;
                    nxt.idx   = '0;
                end
            end
            PH_ID:
            begin
                nxt.id  = {b, cur.id[31:8]};
                nxt.idx = idx + 3'd1;
                if (idx == WORD_LAST_IDX)
                    nxt.phase = PH_NAMELEN;
            end
            PH_NAMELEN:
            begin
                nxt.name_len = b;
                nxt.name_rem = b;
                if (b == 8'd0)
                    finish = 1'b1;
                else
                    nxt.phase = PH_NAME;
            end
            PH_NAME:
            begin
                // Non-printable name bytes are consumed without a result.
                if (b inside {[PRINT_LO:PRINT_HI]})
                begin
                    nxt.name_rem = rem_dec;
                    if (rem_dec == 8'd0)
                    begin
                        finish   = 1'b1;
                        fin_char = b[6:0];
                    end
                    else
                    begin
                        res_valid       = 1'b1;
                        res.record_kind = KIND_CHAR;
                        res.name_char   = b[6:0];
                    end
                end
            end
            default:
            begin
                nxt.phase = PH_IDLE;
            end
        endcase

        if (finish)
        begin
            res_valid       = 1'b1;
            res             = '0;
            res.record_kind = KIND_MOD;
            res.rec_hash    = cur.hash;
            res.workshop_id = cur.id;
            res.name_length = nxt.name_len;
            res.name_char   = fin_char;
            nxt.mods_rem    = mods_dec;
            if (mods_dec == 8'd0)
            begin
                res.end_of_message = 1'b1;
                nxt.phase          = PH_IDLE;
            end
            else
            begin
                nxt.phase = PH_HASH;
                nxt.idx   = '0;
            end
        end
    end

endmodule

// ===== rtl/server_rules_mod_list_parser_core.sv =====
// Top level of the server rules mod list parser.
// Holds the parse state and result registers; depends on srmlp_pkg and srmlp_step.
//
// Channel | Direction | Handshake             | Payload
// byte    | in        | byte_valid/byte_stall | srmlp_pkg::byte_item_t, one reply byte
// rec     | out       | rec_valid/rec_stall   | srmlp_pkg::rec_item_t, one parse result
//
// For each accepted byte the step logic updates the parse state and, when the byte produces
// a result, loads the result register at the same edge. A new byte can be accepted in every
// cycle unless byte_stall is high. The result register is the only buffer, so byte_stall
// is raised exactly while a result is held and rec_stall is high. Reset puts the parser in
// the idle phase, where bytes are dropped until a transaction with message_start arrives.
module server_rules_mod_list_parser_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    output logic                    byte_stall,
    input  srmlp_pkg::byte_item_t   byte_data,
    output logic                    rec_valid,
    input  logic                    rec_stall,
    output srmlp_pkg::rec_item_t    rec_data
);
    import srmlp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    rec_item_t    rec_data_reg;
    rec_item_t    step_res;
    logic         step_res_valid;
    logic         rec_valid_reg;
    logic         rec_valid_next;
    logic         accept;
    logic         out_free;

    srmlp_step u_step (
        .cur       (state_reg),
        .item      (byte_data),
        .nxt       (state_next),
        .res_valid (step_res_valid),
        .res       (step_res)
    );

    // The result register can take a new transaction when it is empty or being drained.
    assign out_free   = !rec_valid_reg || !rec_stall;
    assign byte_stall = !out_free;
    assign accept     = byte_valid && out_free;

    always_comb
    begin
        rec_valid_next = rec_valid_reg;
        if (out_free)
            rec_valid_next = accept && step_res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
            if (accept)
                state_reg <= state_next;
        end
    end

    // Result payload needs no reset; it is qualified by rec_valid_reg.
    always_ff @(posedge clk)
    begin
        if (accept && step_res_valid)
            rec_data_reg <= step_res;
    end

    assign rec_valid = rec_valid_reg;
    assign rec_data  = rec_data_reg;

endmodule

// ===== test/srmlp_parse_checker.sv =====
// Checker for the server rules mod list parser: watches both channels, predicts each result
// from the accepted reply bytes and compares it field by field with what the block delivers.
// Depends on srmlp_pkg for the transaction payload types, parse phases and field constants.
module srmlp_parse_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic                  byte_stall,
    input  srmlp_pkg::byte_item_t byte_data,
    input  logic                  rec_valid,
    input  logic                  rec_stall,
    input  srmlp_pkg::rec_item_t  rec_data,
    output int                    fail_count,
    output int                    pending
);
    import srmlp_pkg::*;

    // Keeps a badly broken block from flooding the log.
    localparam int MAX_REPORTS = 100;

    phase_t      phase;
    logic [2:0]  idx;
    logic [7:0]  version;
    logic [7:0]  overflow;
    logic [15:0] dlc;
    logic [31:0] hash;
    logic [31:0] wid;
    logic [7:0]  nlen;
    logic [7:0]  nrem;
    logic [7:0]  mods_left;

    rec_item_t   expected_recs[$];

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
        end
    endtask

    // A finished mod record; the parser then moves to the next record or goes idle.
    task automatic close_record(input logic [7:0] last_char, output rec_item_t rec);
        rec = '0;
        rec.record_kind = KIND_MOD;
        rec.rec_hash    = hash;
        rec.workshop_id = wid;
        rec.name_length = nlen;
        rec.name_char   = last_char[6:0];
        mods_left = mods_left - 8'd1;
        if (mods_left == 8'd0) begin
            rec.end_of_message = 1'b1;
            phase = PH_IDLE;
        end
        else begin
            phase = PH_HASH;
            idx   = '0;
            hash  = '0;
        end
    endtask

    task automatic parse_byte(input byte_item_t item, output bit has_rec,
                              output rec_item_t rec);
        logic [7:0] b;
        b       = item.data_byte;
        has_rec = 1'b0;
        rec     = '0;
        if (item.message_start) begin
            phase = PH_HEADER;
            idx   = '0;
        end
        case (phase)
            PH_HEADER: begin
                if (idx == HDR_LAST_IDX) begin
                    has_rec          = 1'b1;
                    rec.record_kind  = KIND_HEADER;
                    rec.hdr_version  = version;
                    rec.hdr_overflow = overflow;
                    rec.dlc_mask     = dlc;
                    rec.dlc_single   = $onehot(dlc);
                    rec.mod_count    = b;
                    mods_left        = b;
                    if (b == 8'd0) begin
                        rec.end_of_message = 1'b1;
                        phase = PH_IDLE;
                    end
                    else begin
                        phase = PH_HASH;
                        idx   = '0;
                        hash  = '0;
                    end
                end
                else begin
                    case (idx)
                        3'd0: version = b;
                        3'd1: overflow = b;
                        3'd2: dlc = {8'd0, b};
                        3'd3: dlc[15:8] = b;
                        default: ;
                    endcase
                    idx = idx + 3'd1;
                end
            end
            PH_HASH: begin
                hash |= {24'd0, b} << (8 * idx[1:0]);
                if (idx == WORD_LAST_IDX)
                    phase = PH_IDLEN;
                idx = idx + 3'd1;
            end
            PH_IDLEN: begin
                if (b != ID_LEN) begin
                    has_rec            = 1'b1;
                    rec.record_kind    = KIND_BADLEN;
                    rec.bad_id_length  = b;
                    rec.end_of_message = 1'b1;
                    phase = PH_IDLE;
                end
                else begin
                    phase = PH_ID;
                    idx   = '0;
                    wid   = '0;
                end
            end
            PH_ID: begin
                wid |= {24'd0, b} << (8 * idx[1:0]);
                if (idx == WORD_LAST_IDX)
                    phase = PH_NAMELEN;
                idx = idx + 3'd1;
            end
            PH_NAMELEN: begin
                nlen = b;
                nrem = b;
                if (b == 8'd0) begin
                    has_rec = 1'b1;
                    close_record(8'd0, rec);
                end
                else begin
                    phase = PH_NAME;
                end
            end
            PH_NAME: begin
                // Bytes outside the printable range are swallowed without a result.
                if (b >= PRINT_LO && b <= PRINT_HI) begin
                    has_rec = 1'b1;
                    nrem    = nrem - 8'd1;
                    if (nrem == 8'd0) begin
                        close_record(b, rec);
                    end
                    else begin
                        rec.record_kind = KIND_CHAR;
                        rec.name_char   = b[6:0];
                    end
                end
            end
            PH_IDLE: ;
            default: phase = PH_IDLE;
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        bit        has_rec;
        rec_item_t rec;
        rec_item_t want;
        if (!rst_n) begin
            phase      = PH_IDLE;
            idx        = '0;
            version    = '0;
            overflow   = '0;
            dlc        = '0;
            hash       = '0;
            wid        = '0;
            nlen       = '0;
            nrem       = '0;
            mods_left  = '0;
            fail_count = 0;
            pending    = 0;
            expected_recs.delete();
        end
        else begin
            if (rec_valid && !rec_stall) begin
                if (expected_recs.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: no result expected, got %h", $time, rec_data);
                end
                else begin
                    want = expected_recs.pop_front();
                    check_field("record_kind", 32'(want.record_kind),
                                32'(rec_data.record_kind));
                    check_field("hdr_version", 32'(want.hdr_version),
                                32'(rec_data.hdr_version));
                    check_field("hdr_overflow", 32'(want.hdr_overflow),
                                32'(rec_data.hdr_overflow));
                    check_field("dlc_mask", 32'(want.dlc_mask), 32'(rec_data.dlc_mask));
                    check_field("dlc_single", 32'(want.dlc_single), 32'(rec_data.dlc_single));
                    check_field("mod_count", 32'(want.mod_count), 32'(rec_data.mod_count));
                    check_field("rec_hash", want.rec_hash, rec_data.rec_hash);
                    check_field("workshop_id", want.workshop_id, rec_data.workshop_id);
                    check_field("name_length", 32'(want.name_length),
                                32'(rec_data.name_length));
                    check_field("name_char", 32'(want.name_char), 32'(rec_data.name_char));
                    check_field("bad_id_length", 32'(want.bad_id_length),
                                32'(rec_data.bad_id_length));
                    check_field("end_of_message", 32'(want.end_of_message),
                                32'(rec_data.end_of_message));
                end
            end
            if (byte_valid && !byte_stall) begin
                parse_byte(byte_data, has_rec, rec);
                if (has_rec)
                    expected_recs.push_back(rec);
            end
            pending = expected_recs.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Top of the testbench for server_rules_mod_list_parser_core: clock, reset, reply byte
// stimulus, result stall pattern and the final verdict.
// Depends on srmlp_pkg, the core under test and srmlp_parse_checker.
module tb;
    import srmlp_pkg::*;

    // The slowest correct run handles at most about 2400 bytes (the item
    // target plus one long last message and some noise), each with a random idle gap before
    // it and a random result stall behind it, plus two long receiver hold-offs. The limit
    // leaves a wide margin on top of that.
    localparam int CYCLE_LIMIT = 400000;
    // Number of message bytes after which the random part stops.
    localparam int ITEM_TARGET = 1000;
    // Length of the deliberate receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 300;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    byte_item_t byte_data;
    logic       rec_valid;
    logic       rec_stall;
    rec_item_t  rec_data;

    int         fail_count;
    int         pending;
    int         cycle_cnt = 0;
    int         sent_items = 0;
    int         rx_count = 0;
    // When clear, both sides run flat out; this gives stretches with no idling at all.
    bit         gaps_on = 1'b1;
    // Bytes of the message that is about to be sent.
    logic [7:0] msg_q[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    server_rules_mod_list_parser_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .rec_valid  (rec_valid),
        .rec_stall  (rec_stall),
        .rec_data   (rec_data)
    );

    srmlp_parse_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .rec_valid  (rec_valid),
        .rec_stall  (rec_stall),
        .rec_data   (rec_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("server_rules_mod_list_parser_core test failed");
            $finish;
        end
    end

    // Offers one byte transaction and returns at the rising edge that accepts it. A random
    // number of idle cycles goes before the byte; with no gap, valid simply stays high, so
    // valid is never lowered and raised again in the same time step. Inputs only change on
    // the falling edge, and the stall is looked at on the rising edge.
    task automatic drive_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        repeat (gap) begin
            @(negedge clk);
            byte_valid <= 1'b0;
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_data  <= '{data_byte: b, message_start: start};
        do
            @(posedge clk);
        while (byte_stall);
    endtask

    // Sends msg_q; the first byte carries message_start when asked for. Only bytes of real
    // messages count toward the item target, not the idle noise between them.
    task automatic send_message(input bit with_start, input bit counted);
        for (int i = 0; i < msg_q.size(); i++) begin
            drive_byte(msg_q[i], with_start && (i == 0));
            if (counted)
                sent_items++;
        end
    endtask

    // Receiver: before each result it may hold stall for a random stretch. Twice in the
    // run it holds off for a long stretch instead; the sender keeps offering bytes meanwhile,
    // so the single result register fills and the block has to stall its input.
    initial begin
        int hold;
        rec_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            if (rx_count == 30 || rx_count == 150)
                hold = HOLD_CYCLES;
            else
                hold = gaps_on ? $urandom_range(0, 10) : 0;
            if (hold > 0) begin
                @(negedge clk);
                rec_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            rec_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rec_valid);
            rx_count++;
        end
    end

    initial begin
        logic [15:0] dlc;
        logic [7:0]  idlen;
        int          count;
        int          nl;
        int          chars;
        int          keep;
        int          pick;

        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. A stray byte while idle must be dropped.
        msg_q = '{8'hA5};
        send_message(1'b0, 1'b0);

        // Header with all-ones version and overflow, one DLC bit (the top one) and a zero
        // mod count: the header result itself closes the message.
        msg_q = '{8'hFF, 8'hFF, 8'h00, 8'h80, 8'h12, 8'h34, 8'h00};
        send_message(1'b1, 1'b1);

        // All DLC bits set, two mods. The first has an empty name, so its name length byte
        // finishes the record. The second is cut off inside its hash by the next start.
        msg_q = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h02,
                  8'h78, 8'h56, 8'h34, 8'h12, ID_LEN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h01, 8'h02};
        send_message(1'b1, 1'b1);

        // Mod count 255 and DLC bit 0. The name holds both printable limits with a
        // non-printable byte on either side; the last character completes the record.
        // The next record has an id length of 5, which ends the message with an error.
        msg_q = '{8'h01, 8'h80, 8'h01, 8'h00, 8'h55, 8'hAA, 8'hFF,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, ID_LEN, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h02, 8'h1F, PRINT_LO, 8'h7F, PRINT_HI,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h05};
        send_message(1'b1, 1'b1);

        // Bytes after the end of a message are ignored as well.
        msg_q = '{PRINT_HI, 8'h00};
        send_message(1'b0, 1'b0);

        // Random part: mostly well-formed messages with random content, some cut short
        // (the next start abandons them) and some followed by noise bytes.
        while (sent_items < ITEM_TARGET) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            msg_q.delete();

            msg_q.push_back(8'($urandom_range(0, 255)));
            msg_q.push_back(8'($urandom_range(0, 255)));
            pick = $urandom_range(0, 3);
            if (pick == 0)
                dlc = 16'h0000;
            else if (pick == 1)
                dlc = 16'h0001 << $urandom_range(0, 15);
            else
                dlc = 16'($urandom);
            msg_q.push_back(dlc[7:0]);
            msg_q.push_back(dlc[15:8]);
            msg_q.push_back(8'($urandom_range(0, 255)));
            msg_q.push_back(8'($urandom_range(0, 255)));

            // Usually a few mods; now and then none, or a large count whose message is
            // never finished and gets abandoned by the next start.
            pick = $urandom_range(0, 15);
            if (pick == 0)
                count = 0;
            else if (pick == 1)
                count = $urandom_range(5, 255);
            else
                count = $urandom_range(1, 4);
            msg_q.push_back(8'(count));

            repeat ((count > 4) ? 4 : count) begin
                repeat (4) msg_q.push_back(8'($urandom_range(0, 255)));
                idlen = ID_LEN;
                if ($urandom_range(0, 11) == 0) begin
                    idlen = 8'($urandom_range(0, 255));
                    if (idlen == ID_LEN)
                        idlen = 8'hFF;
                end
                msg_q.push_back(idlen);
                repeat (4) msg_q.push_back(8'($urandom_range(0, 255)));

                // Mostly short names; rarely the longest one the length byte allows.
                pick = $urandom_range(0, 49);
                if (pick == 0)
                    nl = 255;
                else if (pick < 8)
                    nl = 0;
                else
                    nl = $urandom_range(1, 8);
                msg_q.push_back(8'(nl));
                chars = 0;
                while (chars < nl) begin
                    if ($urandom_range(0, 5) == 0) begin
                        if ($urandom_range(0, 1) == 0)
                            msg_q.push_back(8'($urandom_range(0, 31)));
                        else
                            msg_q.push_back(8'($urandom_range(127, 255)));
                    end
                    else begin
                        msg_q.push_back(8'($urandom_range(32, 126)));
                        chars++;
                    end
                end
            end

            // Broken sequence: the message stops anywhere, even inside the header.
            if ($urandom_range(0, 9) == 0) begin
                keep = $urandom_range(1, msg_q.size());
                while (msg_q.size() > keep)
                    void'(msg_q.pop_back());
            end
            send_message(1'b1, 1'b1);

            // Noise without a start flag. After a cut-off message these bytes are parsed
            // as its continuation; after a finished one they are dropped.
            if ($urandom_range(0, 4) == 0) begin
                msg_q.delete();
                repeat ($urandom_range(1, 4)) msg_q.push_back(8'($urandom_range(0, 255)));
                send_message(1'b0, 1'b0);
            end
        end

        @(negedge clk);
        byte_valid <= 1'b0;

        // Drain: every predicted result has to arrive, then a few quiet cycles catch any
        // result the block should not have produced.
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("server_rules_mod_list_parser_core test passed");
        else
            $display("server_rules_mod_list_parser_core test failed");
        $finish;
    end

endmodule
